@@ sv/smf_pkg.sv @@
// Shared types and constants for the sliding median filter.
package smf_pkg;

  // Width of the window length register.
  localparam int CFG_W = 6;

  // Smallest usable window length.
  localparam int LEN_MIN = 3;

  // Window length after reset.
  localparam logic [CFG_W-1:0] LEN_RESET = 6'd5;

  // Controls sent to every cell of the sorting row.
  typedef struct packed {
    logic en;    // a sample is inserted this cycle
    logic clr;   // window is emptied this cycle
    logic full;  // window holds a full length, so the oldest entry leaves
  } cell_ctl_t;

endpackage

@@ sv/smf_cell.sv @@
// One cell of the sorted window row: holds one entry and its age.
module smf_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_W       = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smf_pkg::cell_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [AGE_W-1:0]              old_age,
  input  logic                          l_vld,
  input  logic [AGE_W-1:0]              l_age,
  input  logic signed [SAMPLE_BITS-1:0] l_val,
  input  logic                          r_vld,
  input  logic [AGE_W-1:0]              r_age,
  input  logic signed [SAMPLE_BITS-1:0] r_val,
  input  logic                          rem_in,
  output logic                          rem_out,
  output logic                          vld,
  output logic [AGE_W-1:0]              age,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic signed [SAMPLE_BITS-1:0] val_nxt
);

  logic                          vld_r, vld_nxt;
  logic [AGE_W-1:0]              age_r, age_nxt;
  logic signed [SAMPLE_BITS-1:0] val_r;
  logic                          rem_self;
  logic                          p_vld, c_vld;
  logic [AGE_W-1:0]              p_age, c_age;
  logic signed [SAMPLE_BITS-1:0] p_val, c_val;
  logic                          p_gt, c_gt;

  // This cell or one below it holds the entry that leaves the window.
  assign rem_self = rem_in | (ctl.full & vld_r & (age_r == old_age));
  assign rem_out  = rem_self;

  // Entries of the row with the leaving entry squeezed out: the one that
  // lands below this slot and the one that lands in it.
  always_comb begin
    if (rem_in) begin
      p_vld = vld_r;
      p_age = age_r;
      p_val = val_r;
    end else begin
      p_vld = l_vld;
      p_age = l_age;
      p_val = l_val;
    end
    if (rem_self) begin
      c_vld = r_vld;
      c_age = r_age;
      c_val = r_val;
    end else begin
      c_vld = vld_r;
      c_age = age_r;
      c_val = val_r;
    end
  end

  // Empty slots sort above every sample.
  assign p_gt = !p_vld || (p_val > x);
  assign c_gt = !c_vld || (c_val > x);

  // Entries above the new sample move up one slot; the new sample goes
  // into the first slot whose entry is greater than it.
  always_comb begin
    if (p_gt) begin
      vld_nxt = p_vld;
      age_nxt = p_age + 1'b1;
      val_nxt = p_val;
    end else if (c_gt) begin
      vld_nxt = 1'b1;
      age_nxt = '0;
      val_nxt = x;
    end else begin
      vld_nxt = c_vld;
      age_nxt = c_age + 1'b1;
      val_nxt = c_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clr) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      age_r <= age_nxt;
      val_r <= val_nxt;
    end
  end

  assign vld = vld_r;
  assign age = age_r;
  assign val = val_r;

endmodule

@@ sv/sliding_median_filter.sv @@
// Top level of the sliding-window median filter.
// The filter takes one signed sample per input beat and returns one beat per
// sample: the median of the last window_len samples, flagged on out_tuser,
// or the sample itself (flag low) while the window fills after a reset or a
// length write, and on every beat while the length is not an odd value from
// 3 to MAX_WINDOW. The window is kept as a row of MAX_WINDOW cells that hold
// the stored samples in ascending order, each tagged with its age. On every
// sample each cell looks only at its two neighbors: the oldest entry drops
// out, the larger entries slide up by one cell and the new sample lands in
// the gap, all at once, so the median is simply the middle cell. A new
// beat is accepted in every cycle while the output register is empty or
// being drained, so the block sustains one sample per clock; each result is
// registered. The critical path is the flag that marks the leaving entry as
// it ripples along the whole row, followed by a compare and two selects in
// each cell. Writing the length register empties the window in the same
// cycle; it is meant to be written only while no beat is in flight.
module sliding_median_filter #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, upper bits zero fill
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // out_tdata: [SAMPLE_BITS-1:0] filtered, upper bits zero fill
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // out_tuser: [0] is_median
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [smf_pkg::CFG_W-1:0]              cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AGE_W   = $clog2(MAX_WINDOW);
  localparam int FILL_W  = $clog2(MAX_WINDOW + 1);

  logic [smf_pkg::CFG_W-1:0]     len_r;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_val_r;
  logic                          out_med_r;

  logic signed [SAMPLE_BITS-1:0] x;
  logic                          acc, cfg_wr, len_ok, full, med, upd;
  logic [AGE_W-1:0]              old_age;
  logic [AGE_W-1:0]              mid;
  smf_pkg::cell_ctl_t            ctl;

  logic                          vld_w     [MAX_WINDOW];
  logic [AGE_W-1:0]              age_w     [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] val_w     [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] val_nxt_w [MAX_WINDOW];
  logic                          rem_w     [MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0]         vld_vec;

  assign x         = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Only odd lengths from the minimum up to the row size form a window.
  assign len_ok = (int'(len_r) >= smf_pkg::LEN_MIN) && len_r[0] &&
                  (int'(len_r) <= MAX_WINDOW);

  // With a full window the oldest entry is replaced; the median is due once
  // this sample brings the window to its full length.
  assign full    = (int'(fill_r) == int'(len_r));
  assign med     = len_ok && ((int'(fill_r) + 1) >= int'(len_r));
  assign upd     = acc && len_ok;
  assign old_age = AGE_W'(len_r - 1'b1);
  assign mid     = AGE_W'(len_r >> 1);

  assign ctl.en   = upd && !cfg_wr;
  assign ctl.clr  = cfg_wr;
  assign ctl.full = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= smf_pkg::LEN_RESET;
    end else if (cfg_wr) begin
      len_r <= cfg_data;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_wr) begin
      fill_nxt = '0;
    end else if (upd && !full) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // The leaving-entry flag enters the row at the bottom as zero.
  assign rem_w[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          l_vld, r_vld;
    logic [AGE_W-1:0]              l_age, r_age;
    logic signed [SAMPLE_BITS-1:0] l_val, r_val;

    // Below the bottom cell sits a filled slot holding the most negative
    // value, above the top cell an empty one.
    if (i == 0) begin : g_lo
      assign l_vld = 1'b1;
      assign l_age = '0;
      assign l_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin : g_lo
      assign l_vld = vld_w[i-1];
      assign l_age = age_w[i-1];
      assign l_val = val_w[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_hi
      assign r_vld = 1'b0;
      assign r_age = '0;
      assign r_val = '0;
    end else begin : g_hi
      assign r_vld = vld_w[i+1];
      assign r_age = age_w[i+1];
      assign r_val = val_w[i+1];
    end

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .x       (x),
      .old_age (old_age),
      .l_vld   (l_vld),
      .l_age   (l_age),
      .l_val   (l_val),
      .r_vld   (r_vld),
      .r_age   (r_age),
      .r_val   (r_val),
      .rem_in  (rem_w[i]),
      .rem_out (rem_w[i+1]),
      .vld     (vld_w[i]),
      .age     (age_w[i]),
      .val     (val_w[i]),
      .val_nxt (val_nxt_w[i])
    );

    assign vld_vec[i] = vld_w[i];
  end

  // Output register: it takes a new beat whenever the previous one has been
  // taken or is being taken in this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The median is read from the middle cell's value after this insertion.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_val_r <= med ? val_nxt_w[mid] : x;
      out_med_r <= med;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_val_r);
  assign out_tuser  = out_med_r;

  // The number of occupied cells always matches the fill count.
  a_fill_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(fill_r))
    else $error("occupied cells differ from fill count");

  // A length write leaves the window empty.
  a_cfg_clears : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (fill_r == '0))
    else $error("window not emptied by length write");

  // An accepted beat always shows up in the output register.
  a_acc_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted beat missing at output");

  // Occupied cells form the bottom of the row and stay in ascending order.
  for (genvar k = 0; k < MAX_WINDOW - 1; k++) begin : g_chk
    a_row_sorted : assert property (@(posedge clk) disable iff (!rst_n)
      vld_w[k+1] |-> (vld_w[k] && (val_w[k] <= val_w[k+1])))
      else $error("cell row out of order");
  end

endmodule

@@ bench/tb_sliding_median_filter.sv @@
// Self-checking testbench for the sliding-window median filter.
module tb_sliding_median_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN        = 32;
  localparam int SAMPLE_W       = 16;
  localparam int TDATA_W        = 16;
  localparam int RAND_ITEMS     = 1650;
  localparam int CALM_TAIL      = 150;   // last beats run without any idling
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // Kind of a row in the directed table: a sample beat or a length write.
  typedef enum logic {ROW_SAMPLE, ROW_LEN} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [smf_pkg::CFG_W-1:0] len;
    logic [SAMPLE_W-1:0]       sample;
    logic                      typed;    // expected result is written in the row
    logic [SAMPLE_W-1:0]       exp_filtered;
    logic                      exp_median;
  } dir_row_t;

  // One result beat as the filter should return it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       is_median;
  } filt_beat_t;

  // Row hint handed from the stimulus to the monitor for every sample beat.
  typedef struct packed {
    logic       typed;
    filt_beat_t beat;
  } row_hint_t;

  localparam int DIR_N = 25;

  // Directed rows. Pass-through results are typed in; medians come from the
  // predictor.
  dir_row_t dir_tab [DIR_N] = '{
    // Length 5 after reset: four pass-through beats at the extremes, then
    // the first median.
    '{ROW_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h8000, 1'b1, 16'h8000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0001, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h5555, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'hAAAA, 1'b0, 16'h0000, 1'b0},
    // Even length: pass-through.
    '{ROW_LEN,    6'd4,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h1234, 1'b1, 16'h1234, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    // Below the minimum length.
    '{ROW_LEN,    6'd1,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h8001, 1'b1, 16'h8001, 1'b0},
    '{ROW_LEN,    6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0001, 1'b1, 16'h0001, 1'b0},
    // A length equal to the row size is even, so also pass-through.
    '{ROW_LEN,    6'd32, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h7FFE, 1'b1, 16'h7FFE, 1'b0},
    // Smallest window with equal samples.
    '{ROW_LEN,    6'd3,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0005, 1'b1, 16'h0005, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0005, 1'b1, 16'h0005, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0005, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'hFFFD, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0009, 1'b0, 16'h0000, 1'b0},
    // Rewriting the same length still empties the window.
    '{ROW_LEN,    6'd3,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0007, 1'b1, 16'h0007, 1'b0},
    '{ROW_SAMPLE, 6'd0,  16'h0008, 1'b1, 16'h0008, 1'b0}
  };

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [TDATA_W-1:0]        in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [TDATA_W-1:0]        out_tdata;
  logic                      out_tuser;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [smf_pkg::CFG_W-1:0] cfg_data   = '0;

  // Predictor state: window contents, next slot, fill level and length.
  logic signed [SAMPLE_W-1:0] win_mem [MAX_WIN];
  int win_slot = 0;
  int win_fill = 0;
  int win_len  = int'(smf_pkg::LEN_RESET);

  filt_beat_t filtered_q [$];   // results still owed by the filter
  row_hint_t  hint_q [$];       // one entry per sample beat offered
  int  errors    = 0;
  bit  src_gaps  = 1'b1;
  bit  sink_gaps = 1'b1;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  sliding_median_filter #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_BITS (SAMPLE_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] filtered
    .out_tuser  (out_tuser),  // [0] is_median
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Advances the predicted window by one sample and returns the beat the
  // filter should give for it.
  function automatic filt_beat_t window_median_step(input logic signed [SAMPLE_W-1:0] s);
    filt_beat_t r;
    logic signed [SAMPLE_W-1:0] srt [MAX_WIN];
    logic signed [SAMPLE_W-1:0] v;
    int n;
    int i;
    int j;
    n = win_len;
    r.filtered  = s;
    r.is_median = 1'b0;
    // An unusable length leaves the window untouched.
    if (n < smf_pkg::LEN_MIN || n % 2 == 0 || n > MAX_WIN) return r;
    if (win_slot >= n) win_slot = 0;
    win_mem[win_slot] = s;
    win_slot = (win_slot + 1 >= n) ? 0 : win_slot + 1;
    if (win_fill < n) win_fill++;
    if (win_fill < n) return r;
    for (i = 0; i < n; i++) begin
      v = win_mem[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    r.filtered  = srt[n/2];
    r.is_median = 1'b1;
    return r;
  endfunction

  // Monitor: tracks length writes, predicts each accepted sample and checks
  // each accepted result against the oldest expectation.
  always @(posedge clk) begin
    filt_beat_t exp_b;
    row_hint_t  hint;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        win_len  = int'(cfg_data);
        win_slot = 0;
        win_fill = 0;
      end
      if (in_tvalid && in_tready) begin
        hint  = hint_q.pop_front();
        exp_b = window_median_step(in_tdata[SAMPLE_W-1:0]);
        // Directed rows with a typed result are held to that value.
        if (hint.typed) exp_b = hint.beat;
        filtered_q.push_back(exp_b);
      end
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $error("result beat with nothing expected: filtered %0d is_median %0d",
                 $signed(out_tdata[SAMPLE_W-1:0]), out_tuser);
          errors++;
        end else begin
          exp_b = filtered_q.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== exp_b.filtered) begin
            $error("filtered: expected %0d, actual %0d", exp_b.filtered,
                   $signed(out_tdata[SAMPLE_W-1:0]));
            errors++;
          end
          if (out_tuser !== exp_b.is_median) begin
            $error("is_median: expected %0d, actual %0d", exp_b.is_median, out_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no beat of any kind moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result sink: stalls in random bursts while enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offers one sample beat, starting and ending at a falling edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input row_hint_t hint);
    hint_q.push_back(hint);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the window length once the filter has drained.
  task automatic write_len(input logic [smf_pkg::CFG_W-1:0] len);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Draws a sample: full range, a narrow band full of ties, or extremes.
  function automatic logic [SAMPLE_W-1:0] draw_sample(input int mode);
    logic [SAMPLE_W-1:0] s;
    case (mode)
      0: s = SAMPLE_W'($urandom);
      1: s = SAMPLE_W'($urandom_range(0, 6) - 3);
      default: begin
        case ($urandom_range(0, 4))
          0: s = 16'h7FFF;
          1: s = 16'h8000;
          2: s = 16'h0000;
          3: s = 16'hFFFF;
          default: s = SAMPLE_W'($urandom);
        endcase
      end
    endcase
    return s;
  endfunction

  // Picks a length: mostly short valid windows, sometimes the extremes or
  // an unusable value.
  function automatic logic [smf_pkg::CFG_W-1:0] draw_len();
    logic [smf_pkg::CFG_W-1:0] n;
    case ($urandom_range(0, 19))
      0:       n = 6'd3;
      1:       n = 6'd31;
      2: begin
        case ($urandom_range(0, 3))
          0:       n = 6'd0;
          1:       n = 6'd1;
          2:       n = 6'd2;
          default: n = 6'd32;
        endcase
      end
      3:       n = smf_pkg::CFG_W'(2 * $urandom_range(2, 15));
      4, 5:    n = smf_pkg::CFG_W'(2 * $urandom_range(1, 15) + 1);
      default: n = smf_pkg::CFG_W'(2 * $urandom_range(1, 5) + 1);
    endcase
    return n;
  endfunction

  initial begin
    row_hint_t hint;
    logic [smf_pkg::CFG_W-1:0] len;
    int sent;
    int burst;
    int mode;
    int k;

    // Reset is held at the start and released once.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_LEN) begin
        in_tvalid <= 1'b0;
        write_len(dir_tab[r].len);
      end else begin
        hint.typed          = dir_tab[r].typed;
        hint.beat.filtered  = dir_tab[r].exp_filtered;
        hint.beat.is_median = dir_tab[r].exp_median;
        send_sample(dir_tab[r].sample, hint);
      end
    end
    in_tvalid <= 1'b0;

    // Random phases, each under a freshly written length.
    hint = '0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      len = draw_len();
      write_len(len);
      if (len >= smf_pkg::LEN_MIN && len[0] && len <= MAX_WIN)
        burst = $urandom_range(int'(len), 3 * int'(len) + 40);
      else
        burst = $urandom_range(5, 30);
      mode = $urandom_range(0, 2);
      // Some phases run without any idling at all.
      k = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < burst && sent < RAND_ITEMS; i++) begin
        src_gaps  = !k && (sent < RAND_ITEMS - CALM_TAIL);
        sink_gaps = src_gaps;
        send_sample(draw_sample(mode), hint);
        sent++;
      end
      in_tvalid <= 1'b0;
    end

    // Drain and allow the pipeline to settle.
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && filtered_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sliding_median_filter.f @@
sv/smf_pkg.sv
sv/smf_cell.sv
sv/sliding_median_filter.sv
bench/tb_sliding_median_filter.sv
